### rtl/scp_pkg.sv
package scp_pkg;

  // parameter value 1.0 in unsigned Q1.32
  localparam logic [32:0] T_ONE = 33'h1_0000_0000;
  // squared length at or below this is a point (0.000001 in Q32.32)
  localparam logic signed [66:0] SQ_EPS = 67'sd4295;

  // width of the determinant and its numerator
  localparam int NUM_W = 136;
  // width of the second quotient's operands
  localparam int NB_W = 102;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_start_z;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] a_end_z;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_start_z;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
    logic signed [31:0] b_end_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] near_a_x;
    logic signed [31:0] near_a_y;
    logic signed [31:0] near_a_z;
    logic signed [31:0] near_b_x;
    logic signed [31:0] near_b_y;
    logic signed [31:0] near_b_z;
  } out_t;

  // per-request context carried down the pipeline
  typedef struct packed {
    logic [2:0][31:0] sa;
    logic [2:0][31:0] sb;
    logic [2:0][32:0] da;
    logic [2:0][32:0] db;
    logic signed [66:0] a;
    logic signed [66:0] b;
    logic signed [66:0] c;
    logic signed [66:0] e;
    logic signed [66:0] f;
    logic signed [67:0] nf;
    logic signed [67:0] cf;
    logic [32:0] ta;
    logic apt;
    logic bpt;
    logic par;
    logic neg;
    logic over;
  } ctx_t;

endpackage

### rtl/segment_closest_points_3d_unit.sv
// Closest points between two 3D segments in Q16.16. One request is taken every clock
// while in_stall is low. It passes through four stages of differences, dot products and
// compares, a 9-stage-plus-input split multiplier for the 2x2 determinant, a 33-stage
// divider for A's parameter, a 6-stage-plus-input split multiplier for B's numerator,
// a second 33-stage divider that solves B's parameter or re-solves A's when B is
// clamped, and two stages that place the points. The two bit-per-stage dividers set
// most of the latency. in_stall is high only while a finished result sits in the
// output register and out_stall holds it; the whole pipeline then freezes without
// losing or repeating a request.
module segment_closest_points_3d_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  scp_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output scp_pkg::out_t out_data
);

  localparam int CTX_W = $bits(scp_pkg::ctx_t);

  function automatic logic signed [32:0] diff33(input logic [31:0] x, input logic [31:0] y);
    diff33 = signed'({x[31], x}) - signed'({y[31], y});
  endfunction

  function automatic logic signed [65:0] mul33(input logic [32:0] x, input logic [32:0] y);
    mul33 = signed'(x) * signed'(y);
  endfunction

  function automatic logic signed [66:0] scale(input logic [32:0] dir, input logic [32:0] t);
    scale = signed'(dir) * signed'({1'b0, t});
  endfunction

  logic en;
  logic [2:0][31:0] ias, iae, ibs, ibe;

  logic v1, v2, v3, v4, v5, v7, v9;
  logic [2:0][31:0] s1_sa, s1_sb, s2_sa, s2_sb;
  logic [2:0][32:0] s1_da, s1_db, s1_ds, s2_da, s2_db;
  logic signed [65:0] s2_p [5][3];
  scp_pkg::ctx_t c3, s3, c4, s4, c5, s5, c6, c7, s7, c8, c9;

  logic signed [66:0] m1_a [4];
  logic signed [66:0] m1_b [4];
  logic signed [133:0] m1_p [4];
  logic [CTX_W-1:0] m1_side;
  logic m1_v;

  logic signed [scp_pkg::NUM_W-1:0] s5_det, s5_num;
  logic [32:0] d1_q;
  logic [CTX_W-1:0] d1_side;
  logic d1_v;

  logic signed [66:0] m2_a [1];
  logic signed [33:0] m2_b [1];
  logic signed [100:0] m2_p [1];
  logic [CTX_W-1:0] m2_side;
  logic m2_v;

  logic signed [scp_pkg::NB_W-1:0] s7_nb, bs, d2_n, d2_d;
  logic [32:0] d2_q;
  logic [CTX_W-1:0] d2_side;
  logic d2_v;

  logic [32:0] ta, tb;
  logic [2:0][31:0] s9_sa, s9_sb;
  logic signed [66:0] s9_pa [3];
  logic signed [66:0] s9_pb [3];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    ias = {in_data.a_start_z, in_data.a_start_y, in_data.a_start_x};
    iae = {in_data.a_end_z, in_data.a_end_y, in_data.a_end_x};
    ibs = {in_data.b_start_z, in_data.b_start_y, in_data.b_start_x};
    ibe = {in_data.b_end_z, in_data.b_end_y, in_data.b_end_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v7 <= 1'b0;
      v9 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= m1_v;
      v7 <= m2_v;
      v9 <= d2_v;
      out_valid <= v9;
    end
  end

  // differences, then the fifteen coordinate products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_da[k] <= diff33(iae[k], ias[k]);
        s1_db[k] <= diff33(ibe[k], ibs[k]);
        s1_ds[k] <= diff33(ias[k], ibs[k]);
        s2_p[0][k] <= mul33(s1_da[k], s1_da[k]);
        s2_p[1][k] <= mul33(s1_db[k], s1_db[k]);
        s2_p[2][k] <= mul33(s1_da[k], s1_db[k]);
        s2_p[3][k] <= mul33(s1_db[k], s1_ds[k]);
        s2_p[4][k] <= mul33(s1_da[k], s1_ds[k]);
      end
      s1_sa <= ias;
      s1_sb <= ibs;
      s2_sa <= s1_sa;
      s2_sb <= s1_sb;
      s2_da <= s1_da;
      s2_db <= s1_db;
      s3 <= c3;
      s4 <= c4;
    end
  end

  always_comb begin
    c3 = '0;
    c3.sa = s2_sa;
    c3.sb = s2_sb;
    c3.da = s2_da;
    c3.db = s2_db;
    c3.a = 67'(s2_p[0][0]) + 67'(s2_p[0][1]) + 67'(s2_p[0][2]);
    c3.b = 67'(s2_p[1][0]) + 67'(s2_p[1][1]) + 67'(s2_p[1][2]);
    c3.c = 67'(s2_p[2][0]) + 67'(s2_p[2][1]) + 67'(s2_p[2][2]);
    c3.e = 67'(s2_p[3][0]) + 67'(s2_p[3][1]) + 67'(s2_p[3][2]);
    c3.f = 67'(s2_p[4][0]) + 67'(s2_p[4][1]) + 67'(s2_p[4][2]);
  end

  always_comb begin
    c4 = s3;
    c4.apt = s3.a <= scp_pkg::SQ_EPS;
    c4.bpt = s3.b <= scp_pkg::SQ_EPS;
    c4.nf = -68'(s3.f);
    c4.cf = 68'(s3.c) - 68'(s3.f);
  end

  // a*b, c*c, c*e, f*b
  always_comb begin
    m1_a[0] = s4.a;
    m1_b[0] = s4.b;
    m1_a[1] = s4.c;
    m1_b[1] = s4.c;
    m1_a[2] = s4.c;
    m1_b[2] = s4.e;
    m1_a[3] = s4.f;
    m1_b[3] = s4.b;
  end

  scp_mul #(
    .WA(67),
    .WB(67),
    .N(4),
    .PW(CTX_W)
  ) u_mul_det (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v4),
    .a(m1_a),
    .b(m1_b),
    .side_in(s4),
    .out_valid(m1_v),
    .p(m1_p),
    .side_out(m1_side)
  );

  always_comb begin
    c5 = scp_pkg::ctx_t'(m1_side);
    c5.par = m1_p[0] == m1_p[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_det <= scp_pkg::NUM_W'(m1_p[0]) - scp_pkg::NUM_W'(m1_p[1]);
      s5_num <= scp_pkg::NUM_W'(m1_p[2]) - scp_pkg::NUM_W'(m1_p[3]);
      s5 <= c5;
    end
  end

  scp_div #(
    .W(scp_pkg::NUM_W),
    .PW(CTX_W)
  ) u_div_a (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v5),
    .n(s5_num),
    .d(s5_det),
    .side_in(s5),
    .out_valid(d1_v),
    .q(d1_q),
    .side_out(d1_side)
  );

  // parallel segments pin A's parameter to zero
  always_comb begin
    c6 = scp_pkg::ctx_t'(d1_side);
    c6.ta = c6.par ? 33'd0 : d1_q;
    m2_a[0] = c6.c;
    m2_b[0] = signed'({1'b0, c6.ta});
  end

  scp_mul #(
    .WA(67),
    .WB(34),
    .N(1),
    .PW(CTX_W)
  ) u_mul_nb (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(d1_v),
    .a(m2_a),
    .b(m2_b),
    .side_in(c6),
    .out_valid(m2_v),
    .p(m2_p),
    .side_out(m2_side)
  );

  assign c7 = scp_pkg::ctx_t'(m2_side);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nb <= scp_pkg::NB_W'(m2_p[0]) + (scp_pkg::NB_W'(c7.e) <<< 32);
      s7 <= c7;
    end
  end

  // pick the second quotient: B's parameter, or A's against a clamped end of B
  always_comb begin
    bs = scp_pkg::NB_W'(s7.b) <<< 32;
    c8 = s7;
    c8.neg = s7_nb[scp_pkg::NB_W-1];
    c8.over = !s7_nb[scp_pkg::NB_W-1] && (s7_nb > bs);
    priority if (s7.apt) begin
      d2_n = scp_pkg::NB_W'(s7.e);
      d2_d = scp_pkg::NB_W'(s7.b);
    end else if (s7.bpt || c8.neg) begin
      d2_n = scp_pkg::NB_W'(s7.nf);
      d2_d = scp_pkg::NB_W'(s7.a);
    end else if (c8.over) begin
      d2_n = scp_pkg::NB_W'(s7.cf);
      d2_d = scp_pkg::NB_W'(s7.a);
    end else begin
      d2_n = s7_nb;
      d2_d = bs;
    end
  end

  scp_div #(
    .W(scp_pkg::NB_W),
    .PW(CTX_W)
  ) u_div_b (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v7),
    .n(d2_n),
    .d(d2_d),
    .side_in(c8),
    .out_valid(d2_v),
    .q(d2_q),
    .side_out(d2_side)
  );

  always_comb begin
    c9 = scp_pkg::ctx_t'(d2_side);
    priority if (c9.apt) begin
      ta = '0;
      tb = c9.bpt ? 33'd0 : d2_q;
    end else if (c9.bpt || c9.neg) begin
      ta = d2_q;
      tb = '0;
    end else if (c9.over) begin
      ta = d2_q;
      tb = scp_pkg::T_ONE;
    end else begin
      ta = c9.ta;
      tb = d2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s9_pa[k] <= scale(c9.da[k], ta);
        s9_pb[k] <= scale(c9.db[k], tb);
      end
      s9_sa <= c9.sa;
      s9_sb <= c9.sb;
      // point = start + floor(dir * t / 2^32)
      out_data.near_a_x <= s9_sa[0] + s9_pa[0][63:32];
      out_data.near_a_y <= s9_sa[1] + s9_pa[1][63:32];
      out_data.near_a_z <= s9_sa[2] + s9_pa[2][63:32];
      out_data.near_b_x <= s9_sb[0] + s9_pb[0][63:32];
      out_data.near_b_y <= s9_sb[1] + s9_pb[1][63:32];
      out_data.near_b_z <= s9_sb[2] + s9_pb[2][63:32];
    end
  end

  a_ta_range: assert property (@(posedge clk) disable iff (rst)
    d1_v |-> (d1_q <= scp_pkg::T_ONE))
    else $error("first quotient above one");

  a_tb_range: assert property (@(posedge clk) disable iff (rst)
    d2_v |-> (d2_q <= scp_pkg::T_ONE))
    else $error("second quotient above one");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v9) && $stable(v7) && $stable(v5)))
    else $error("pipeline moved while output held");

endmodule

### rtl/scp_mul.sv
module scp_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int N = 1,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [WA-1:0] a [N],
  input  logic signed [WB-1:0] b [N],
  input  logic [PW-1:0] side_in,
  output logic out_valid,
  output logic signed [WA+WB-1:0] p [N],
  output logic [PW-1:0] side_out
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int NS = NA * NB;
  localparam int WAX = NA * 32;
  localparam int WBX = NB * 32;
  localparam int WPX = WAX + WBX + 1;

  logic [NS:0] vld;
  logic [PW-1:0] sd [NS+1];
  logic [WAX-1:0] ar [NS+1][N];
  logic [WBX-1:0] br [NS+1][N];
  logic signed [WPX-1:0] acc [NS+1][N];
  logic signed [WPX-1:0] ppx [NS][N];

  // one 32x32 slice pair per stage, top slices signed
  always_comb begin
    logic signed [32:0] ax;
    logic signed [32:0] bx;
    logic signed [65:0] pp;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        for (int n = 0; n < N; n++) begin
          if (i == NA - 1) begin
            ax = signed'({ar[i*NB+j][n][32*i+31], ar[i*NB+j][n][32*i +: 32]});
          end else begin
            ax = signed'({1'b0, ar[i*NB+j][n][32*i +: 32]});
          end
          if (j == NB - 1) begin
            bx = signed'({br[i*NB+j][n][32*j+31], br[i*NB+j][n][32*j +: 32]});
          end else begin
            bx = signed'({1'b0, br[i*NB+j][n][32*j +: 32]});
          end
          pp = ax * bx;
          ppx[i*NB+j][n] = WPX'(pp) <<< (32 * (i + j));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int n = 0; n < N; n++) begin
        ar[0][n] <= WAX'(a[n]);
        br[0][n] <= WBX'(b[n]);
        acc[0][n] <= '0;
      end
      for (int k = 0; k < NS; k++) begin
        sd[k+1] <= sd[k];
        for (int n = 0; n < N; n++) begin
          ar[k+1][n] <= ar[k][n];
          br[k+1][n] <= br[k][n];
          acc[k+1][n] <= acc[k][n] + ppx[k][n];
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      p[n] = acc[NS][n][WA+WB-1:0];
    end
  end

  assign out_valid = vld[NS];
  assign side_out = sd[NS];

endmodule

### rtl/scp_div.sv
module scp_div #(
  parameter int W = 64,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [W-1:0] n,
  input  logic signed [W-1:0] d,
  input  logic [PW-1:0] side_in,
  output logic out_valid,
  output logic [32:0] q,
  output logic [PW-1:0] side_out
);

  localparam int NB = 32;

  logic [NB:0] vld;
  logic [NB:0] zf;
  logic [NB:0] of;
  logic [W-1:0] rr [NB+1];
  logic [W-1:0] dd [NB+1];
  logic [NB-1:0] qq [NB+1];
  logic [PW-1:0] sd [NB+1];
  logic [W-1:0] r_next [NB];
  logic [NB-1:0] ge;

  // restoring step, one quotient bit per stage
  always_comb begin
    logic [W:0] r2;
    for (int k = 0; k < NB; k++) begin
      r2 = {rr[k], 1'b0};
      ge[k] = r2 >= {1'b0, dd[k]};
      if (ge[k]) begin
        r_next[k] = W'(r2 - {1'b0, dd[k]});
      end else begin
        r_next[k] = W'(r2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= n;
      dd[0] <= d;
      qq[0] <= '0;
      sd[0] <= side_in;
      zf[0] <= n[W-1] || (n == '0);
      of[0] <= !n[W-1] && (n != '0) && (n >= d);
      for (int k = 0; k < NB; k++) begin
        rr[k+1] <= r_next[k];
        dd[k+1] <= dd[k];
        qq[k+1] <= {qq[k][NB-2:0], ge[k]};
        sd[k+1] <= sd[k];
        zf[k+1] <= zf[k];
        of[k+1] <= of[k];
      end
    end
  end

  always_comb begin
    priority if (of[NB]) begin
      q = scp_pkg::T_ONE;
    end else if (zf[NB]) begin
      q = '0;
    end else begin
      q = {1'b0, qq[NB]};
    end
  end

  assign out_valid = vld[NB];
  assign side_out = sd[NB];

endmodule
